/* rtl/core/tmrle_pkg.sv */
// shared types and constants for the tone-mapped run-length encoder
// film curve knot tables, neutral weights, byte scale and queue item type
// no dependencies
package tmrle_pkg;

	localparam int CURVE_KNOTS = 17;
	localparam int SEG_W       = $clog2(CURVE_KNOTS);
	localparam int KNOT_W      = 17;
	// widest knot spacing on input fits 14 bits, widest rise on output 13 bits
	localparam int DX_W        = 14;
	localparam int DY_W        = 13;
	localparam int QUOT_W      = DY_W;
	localparam int NUM_W       = DX_W + DY_W;
	localparam int PROD_W      = 41;

	localparam logic [15:0] W_RED   = 16'd19661;
	localparam logic [15:0] W_GREEN = 16'd38666;
	localparam logic [15:0] W_BLUE  = 16'd7209;
	// 255.9999 in q16
	localparam logic [23:0] BYTE_SCALE = 24'd16777209;

	localparam logic [1:0] FILT_RED     = 2'd0;
	localparam logic [1:0] FILT_GREEN   = 2'd1;
	localparam logic [1:0] FILT_BLUE    = 2'd2;
	localparam logic [1:0] FILT_NEUTRAL = 2'd3;

	localparam logic [KNOT_W-1:0] KNOT_IN [CURVE_KNOTS] = '{
		17'd0, 17'd26, 17'd52, 17'd118, 17'd216, 17'd400, 17'd780, 17'd1324, 17'd2444,
		17'd4260, 17'd7406, 17'd13042, 17'd19661, 17'd28312, 17'd39059, 17'd50266,
		17'd65536
	};
	localparam logic [KNOT_W-1:0] KNOT_OUT [CURVE_KNOTS] = '{
		17'd0, 17'd3867, 17'd7995, 17'd12059, 17'd16187, 17'd20316, 17'd24445, 17'd28508,
		17'd32637, 17'd36766, 17'd40894, 17'd44958, 17'd49086, 17'd53215, 17'd57344,
		17'd61407, 17'd65536
	};

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [7:0] value;
		logic       eol;
	} tmrle_item_t;

endpackage

/* rtl/core/tmrle_front.sv */
// front end: accepts a pixel, forms the filter value and maps it through the film curve
// to a byte; uses tmrle_pkg, feeds tmrle_fifo
module tmrle_front import tmrle_pkg::*; #(
	parameter int COLOR_FRAC_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [1:0]  filter_select,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] red,
	input  logic [15:0] green,
	input  logic [15:0] blue,
	input  logic        end_of_line,
	output logic        push,
	output tmrle_item_t item,
	input  logic        full
);

	localparam int CNT_W = $clog2(QUOT_W + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_MUL, ST_ADD, ST_SEG, ST_PROD, ST_DIV, ST_SCALE, ST_PUSH
	} state_t;

	state_t              state_q;
	logic [1:0]          sel_q;
	logic [15:0]         red_q, green_q, blue_q;
	logic                eol_q;
	logic [31:0]         tr_q, tg_q, tb_q;
	logic                sat_q;
	logic [15:0]         y16_q;
	logic [DX_W-1:0]     d_q, dx_q, rem_q;
	logic [DY_W-1:0]     dy_q;
	logic [KNOT_W-1:0]   y0_q;
	logic [QUOT_W-1:0]   num_q, quot_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [PROD_W-1:0]   prod_q;

	logic [31:0]         sum_c;
	logic [32:0]         one_c;
	logic [SEG_W-1:0]    seg_c, seg_nx_c;
	logic [KNOT_W-1:0]   x0_c, dx_full_c, dy_full_c, d_full_c, out16_c;
	logic [NUM_W-1:0]    num_c;
	logic [DX_W:0]       rem_sh_c, rem_sub_c;
	logic                ge_c;

	assign one_c = 33'(1) << (COLOR_FRAC_BITS + 16);

	always_comb begin
		case (sel_q)
			FILT_RED:   sum_c = {red_q, 16'h0000};
			FILT_GREEN: sum_c = {green_q, 16'h0000};
			FILT_BLUE:  sum_c = {blue_q, 16'h0000};
			default:    sum_c = tr_q + tg_q + tb_q;
		endcase
	end

	// last knot at or below the filter value picks the segment
	always_comb begin
		seg_c = '0;
		for (int i = 1; i < CURVE_KNOTS - 1; i++) begin
			if ({1'b0, y16_q} >= KNOT_IN[i])
				seg_c = SEG_W'(i);
		end
	end

	assign seg_nx_c  = seg_c + 1'b1;
	assign x0_c      = KNOT_IN[seg_c];
	assign dx_full_c = KNOT_IN[seg_nx_c] - x0_c;
	assign dy_full_c = KNOT_OUT[seg_nx_c] - KNOT_OUT[seg_c];
	assign d_full_c  = {1'b0, y16_q} - x0_c;

	assign num_c = NUM_W'(d_q) * NUM_W'(dy_q);

	// one quotient bit per cycle, restoring
	assign rem_sh_c  = {rem_q, num_q[QUOT_W-1]};
	assign ge_c      = rem_sh_c >= {1'b0, dx_q};
	assign rem_sub_c = rem_sh_c - {1'b0, dx_q};

	assign out16_c = y0_q + ((dx_q != '0) ? KNOT_W'(quot_q) : '0);

	assign in_stall   = (state_q != ST_IDLE);
	assign push       = (state_q == ST_PUSH) && !full;
	assign item.value = sat_q ? 8'hFF : prod_q[39:32];
	assign item.eol   = eol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						sel_q   <= filter_select;
						red_q   <= red;
						green_q <= green;
						blue_q  <= blue;
						eol_q   <= end_of_line;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					tr_q    <= 32'(red_q) * 32'(W_RED);
					tg_q    <= 32'(green_q) * 32'(W_GREEN);
					tb_q    <= 32'(blue_q) * 32'(W_BLUE);
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					sat_q   <= {1'b0, sum_c} >= one_c;
					y16_q   <= 16'(sum_c >> COLOR_FRAC_BITS);
					state_q <= ST_SEG;
				end
				ST_SEG: begin
					d_q     <= DX_W'(d_full_c);
					dx_q    <= DX_W'(dx_full_c);
					dy_q    <= DY_W'(dy_full_c);
					y0_q    <= KNOT_OUT[seg_c];
					state_q <= ST_PROD;
				end
				ST_PROD: begin
					// quotient stays below dy, so the top bits already sit under dx
					rem_q   <= num_c[NUM_W-1:QUOT_W];
					num_q   <= num_c[QUOT_W-1:0];
					quot_q  <= '0;
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q  <= ge_c ? rem_sub_c[DX_W-1:0] : rem_sh_c[DX_W-1:0];
					quot_q <= {quot_q[QUOT_W-2:0], ge_c};
					num_q  <= {num_q[QUOT_W-2:0], 1'b0};
					cnt_q  <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(QUOT_W - 1))
						state_q <= ST_SCALE;
				end
				ST_SCALE: begin
					prod_q  <= PROD_W'(out16_c) * PROD_W'(BYTE_SCALE);
					state_q <= ST_PUSH;
				end
				ST_PUSH: begin
					if (!full)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

/* rtl/core/tmrle_fifo.sv */
// short queue of tone-mapped bytes between the front end and the run coder
// uses tmrle_pkg for the item type and depth
module tmrle_fifo import tmrle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  tmrle_item_t wr_item,
	output logic        full,
	input  logic        pop,
	output tmrle_item_t rd_item,
	output logic        empty
);

	tmrle_item_t       mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   fill_q;

	assign full    = (fill_q == (QPTR_W + 1)'(QUEUE_DEPTH));
	assign empty   = (fill_q == '0);
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

/* rtl/core/tmrle_rle.sv */
// back end: merges equal bytes into (value, count) runs and drives the output channel
// uses tmrle_pkg, pops from tmrle_fifo
module tmrle_rle import tmrle_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  tmrle_item_t rd_item,
	input  logic        empty,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  run_value,
	output logic [7:0]  run_count,
	output logic        last_of_line
);

	logic [7:0] cur_value_q, cur_count_q;
	logic       run_open_q;
	logic       out_valid_q;
	logic [7:0] out_value_q, out_count_q;
	logic       out_last_q;
	logic       pend_valid_q;
	logic [7:0] pend_value_q, pend_count_q;

	logic       out_free_c, extend_c, close_c;
	logic [7:0] new_value_c, new_count_c;

	assign out_free_c = !out_valid_q || !out_stall;
	assign pop        = out_free_c && !pend_valid_q && !empty;

	assign extend_c    = run_open_q && (rd_item.value == cur_value_q) && (cur_count_q != 8'hFF);
	assign close_c     = run_open_q && !extend_c;
	assign new_value_c = extend_c ? cur_value_q : rd_item.value;
	assign new_count_c = extend_c ? cur_count_q + 1'b1 : 8'd1;

	assign out_valid    = out_valid_q;
	assign run_value    = out_value_q;
	assign run_count    = out_count_q;
	assign last_of_line = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_value_q  <= '0;
			cur_count_q  <= '0;
			run_open_q   <= 1'b0;
			out_valid_q  <= 1'b0;
			pend_valid_q <= 1'b0;
		end else if (out_free_c) begin
			if (pend_valid_q) begin
				// end-of-line run held back behind the closed run
				out_valid_q  <= 1'b1;
				out_value_q  <= pend_value_q;
				out_count_q  <= pend_count_q;
				out_last_q   <= 1'b1;
				pend_valid_q <= 1'b0;
			end else if (!empty) begin
				if (rd_item.eol) begin
					cur_value_q <= '0;
					cur_count_q <= '0;
					run_open_q  <= 1'b0;
				end else begin
					cur_value_q <= new_value_c;
					cur_count_q <= new_count_c;
					run_open_q  <= 1'b1;
				end
				if (close_c) begin
					out_valid_q  <= 1'b1;
					out_value_q  <= cur_value_q;
					out_count_q  <= cur_count_q;
					out_last_q   <= 1'b0;
					pend_valid_q <= rd_item.eol;
					pend_value_q <= new_value_c;
					pend_count_q <= new_count_c;
				end else if (rd_item.eol) begin
					out_valid_q <= 1'b1;
					out_value_q <= new_value_c;
					out_count_q <= new_count_c;
					out_last_q  <= 1'b1;
				end else begin
					out_valid_q <= 1'b0;
				end
			end else begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/core/tone_mapped_run_length_encoder_top.sv */
// Tone-mapped run-length encoder.
// Input channel (in_valid / in_stall): one pixel per transaction, red, green and blue
// in unsigned fixed point with 2^COLOR_FRAC_BITS = 1.0, end_of_line on the last pixel.
// Output channel (out_valid / out_stall): (run_value, run_count) pairs, last_of_line set
// on the final pair of a scanline. A pixel yields zero, one or two pairs.
// Configuration channel (cfg_valid / cfg_ready): writes filter_select, 0 red, 1 green,
// 2 blue, 3 neutral weighted sum. Always ready; write only while the block is idle.
// The front end works on one pixel at a time, its pace set mostly by the serial divider
// of the curve interpolation. A 4-entry queue lets the front end move on to the next
// pixel while the run coder waits on the receiver.
// A run's pair passes from the front end through the queue into the output register
// once the pixel that closes it is taken by the run coder and the output is free.
// When out_stall is high the pair and the one behind it are held; once the queue is full
// the front end holds its byte and in_stall stays high.
// Reset clears the queue, the open run and filter_select (red); no clearing pass.
module tone_mapped_run_length_encoder_top import tmrle_pkg::*; #(
	parameter int COLOR_FRAC_BITS = 14
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  filter_select,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [15:0] red,
	input  logic [15:0] green,
	input  logic [15:0] blue,
	input  logic        end_of_line,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  run_value,
	output logic [7:0]  run_count,
	output logic        last_of_line
);

	logic [1:0]  filter_select_q;
	logic        push, full, pop, empty;
	tmrle_item_t wr_item, rd_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filter_select_q <= FILT_RED;
		end else if (cfg_valid) begin
			filter_select_q <= filter_select;
		end
	end

	tmrle_front #(
		.COLOR_FRAC_BITS(COLOR_FRAC_BITS)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.filter_select(filter_select_q),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.red          (red),
		.green        (green),
		.blue         (blue),
		.end_of_line  (end_of_line),
		.push         (push),
		.item         (wr_item),
		.full         (full)
	);

	tmrle_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_item(wr_item),
		.full   (full),
		.pop    (pop),
		.rd_item(rd_item),
		.empty  (empty)
	);

	tmrle_rle u_rle (
		.clk         (clk),
		.arst_n      (arst_n),
		.rd_item     (rd_item),
		.empty       (empty),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.run_value   (run_value),
		.run_count   (run_count),
		.last_of_line(last_of_line)
	);

endmodule
